### hdl/lpr_pkg.sv
// Shared types, constants and helper functions for the log-polar remap block.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package lpr_pkg;

    localparam int SRC_SIDE = 512;
    localparam int OUT_SIDE = 512;
    localparam int PIX_W    = 16;
    localparam int FRAC_W   = 8;
    localparam int SIDE_W   = 10;
    localparam int SIDX_W   = 9;
    localparam int OIDX_W   = 9;
    localparam int RAD_W    = 24;
    localparam int TRIG_W   = 16;
    localparam int PROD_W   = TRIG_W + RAD_W + 1;
    localparam int POS_W    = 28;
    localparam int QDEPTH   = 4;

    localparam logic [1:0] REQ_PIX  = 2'd0;
    localparam logic [1:0] REQ_CALC = 2'd1;
    localparam logic [1:0] REQ_RAD  = 2'd2;
    localparam logic [1:0] REQ_ANG  = 2'd3;

    localparam logic [1:0] CFG_SRC_W = 2'd0;
    localparam logic [1:0] CFG_SRC_H = 2'd1;
    localparam logic [1:0] CFG_OUT_W = 2'd2;
    localparam logic [1:0] CFG_OUT_H = 2'd3;

    typedef struct packed {
        logic [SIDE_W-1:0] src_w;
        logic [SIDE_W-1:0] src_h;
        logic [SIDE_W-1:0] out_w;
        logic [SIDE_W-1:0] out_h;
    } sides_t;

    typedef struct packed {
        logic              is_wr;
        logic [SIDX_W-1:0] x0;
        logic [SIDX_W-1:0] x1;
        logic [SIDX_W-1:0] y0;
        logic [SIDX_W-1:0] y1;
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
        logic [PIX_W-1:0]  pix;
        logic [OIDX_W-1:0] row;
        logic [OIDX_W-1:0] col;
    } cmd_t;

    // A side of zero acts as one, a side above the maximum acts as the maximum.
    function automatic logic [SIDE_W-1:0] sat_side(input logic [SIDE_W-1:0] v,
                                                   input logic [SIDE_W-1:0] mx);
        logic [SIDE_W-1:0] r;
        begin
            if (v == '0)
                r = SIDE_W'(1);
            else if (v > mx)
                r = mx;
            else
                r = v;
            return r;
        end
    endfunction

endpackage
`default_nettype wire

### hdl/lpr_fifo.sv
// Short command queue between the front and back parts.
// Depends on lpr_pkg for the command type and depth.
`default_nettype none
module lpr_fifo
    import lpr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_data,
    output logic      full,
    input  wire logic pop,
    output cmd_t      pop_data,
    output logic      empty
);
    localparam int PW = $clog2(QDEPTH);

    cmd_t           mem [QDEPTH];
    logic [PW-1:0]  wp_reg, wp_next, rp_reg, rp_next;
    logic [PW:0]    cnt_reg, cnt_next;

    assign full     = (cnt_reg == (PW+1)'(QDEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem[rp_reg];

    always_comb
    begin
        wp_next  = push ? wp_reg + PW'(1) : wp_reg;
        rp_next  = pop ? rp_reg + PW'(1) : rp_reg;
        cnt_next = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

### hdl/lpr_front.sv
// Front part: accepts request beats, keeps the radius and angle tables, and turns
// compute requests into clamped source positions. Depends on lpr_pkg.
`default_nettype none
module lpr_front
    import lpr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  sides_t                   sides,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire logic [1:0]          req_type,
    input  wire logic [SIDX_W-1:0]   pos_x,
    input  wire logic [SIDX_W-1:0]   pos_y,
    input  wire logic [PIX_W-1:0]    pixel_value,
    input  wire logic [OIDX_W-1:0]   table_index,
    input  wire logic [RAD_W-1:0]    radius_value,
    input  wire logic [TRIG_W-1:0]   cos_value,
    input  wire logic [TRIG_W-1:0]   sin_value,
    output logic                     push,
    output cmd_t                     cmd,
    input  wire logic                full
);
    logic [RAD_W-1:0]    rad_mem [OUT_SIDE];
    logic [2*TRIG_W-1:0] ang_mem [OUT_SIDE];
    logic [RAD_W-1:0]    rad_q_reg;
    logic [2*TRIG_W-1:0] ang_q_reg;

    logic en, acc, tix_ok, img_ok, cmp_ok;

    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic wr0_reg, wr1_reg, wr2_reg;
    logic [SIDX_W-1:0] px0_reg, py0_reg, px1_reg, py1_reg, px2_reg, py2_reg;
    logic [PIX_W-1:0]  pix0_reg, pix1_reg, pix2_reg;
    logic signed [PROD_W-1:0] prx_reg, pry_reg;
    logic signed [PROD_W-1:0] rndx, rndy;
    logic signed [POS_W-1:0]  posx_reg, posy_reg, posx_next, posy_next;
    logic [SIDX_W+FRAC_W-1:0] cen_x, cen_y;
    cmd_t cmd_reg, cmd_next;

    assign en        = !(v3_reg && full);
    assign req_stall = !en;
    assign acc       = req_valid && en;
    assign push      = v3_reg && !full;
    assign cmd       = cmd_reg;

    assign tix_ok = ({1'b0, table_index} < SIDE_W'(OUT_SIDE));
    assign img_ok = (req_type == REQ_PIX) && ({1'b0, pos_x} < SIDE_W'(SRC_SIDE))
                    && ({1'b0, pos_y} < SIDE_W'(SRC_SIDE));
    assign cmp_ok = (req_type == REQ_CALC) && ({1'b0, pos_x} < sides.out_w)
                    && ({1'b0, pos_y} < sides.out_h);

    // Centre of the image is side / 2 in fixed point.
    assign cen_x = (SIDX_W+FRAC_W)'({sides.src_w, {(FRAC_W-1){1'b0}}});
    assign cen_y = (SIDX_W+FRAC_W)'({sides.src_h, {(FRAC_W-1){1'b0}}});

    always_ff @(posedge clk)
    begin
        if (acc && req_type == REQ_RAD && tix_ok)
            rad_mem[table_index] <= radius_value;
        if (acc && req_type == REQ_ANG && tix_ok)
            ang_mem[table_index] <= {cos_value, sin_value};
        if (en)
        begin
            rad_q_reg <= rad_mem[pos_x];
            ang_q_reg <= ang_mem[pos_y];
        end
    end

    // Clamp a position to [0, (side-1)] and split it into neighbours and fraction.
    function automatic void split_pos(input logic signed [POS_W-1:0] p,
                                      input logic [SIDE_W-1:0] side,
                                      output logic [SIDX_W-1:0] i0,
                                      output logic [SIDX_W-1:0] i1,
                                      output logic [FRAC_W-1:0] f);
        logic [SIDE_W+FRAC_W-1:0] hi;
        logic [SIDE_W+FRAC_W-1:0] c;
        logic [SIDE_W-1:0]        nx;
        begin
            hi = {side - SIDE_W'(1), {FRAC_W{1'b0}}};
            if (p < 0)
                c = '0;
            else if (p > $signed(POS_W'(hi)))
                c = hi;
            else
                c = (SIDE_W+FRAC_W)'(p);
            i0 = c[FRAC_W +: SIDX_W];
            f  = c[FRAC_W-1:0];
            nx = {1'b0, i0} + SIDE_W'(1);
            i1 = (nx < side) ? nx[SIDX_W-1:0] : SIDX_W'(side - SIDE_W'(1));
        end
    endfunction

    always_comb
    begin
        rndx = prx_reg + PROD_W'(1 << (TRIG_W-2));
        rndy = pry_reg + PROD_W'(1 << (TRIG_W-2));
        posx_next = POS_W'($signed(rndx[PROD_W-1:TRIG_W-1])) + POS_W'(cen_x);
        posy_next = POS_W'($signed(rndy[PROD_W-1:TRIG_W-1])) + POS_W'(cen_y);
        cmd_next = '0;
        cmd_next.is_wr = wr2_reg;
        cmd_next.pix   = pix2_reg;
        cmd_next.row   = py2_reg;
        cmd_next.col   = px2_reg;
        if (wr2_reg)
        begin
            cmd_next.x0 = px2_reg;
            cmd_next.y0 = py2_reg;
        end
        else
        begin
            split_pos(posx_reg, sides.src_w, cmd_next.x0, cmd_next.x1, cmd_next.fx);
            split_pos(posy_reg, sides.src_h, cmd_next.y0, cmd_next.y1, cmd_next.fy);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wr0_reg  <= (req_type == REQ_PIX);
            px0_reg  <= pos_x;
            py0_reg  <= pos_y;
            pix0_reg <= pixel_value;
            wr1_reg  <= wr0_reg;
            px1_reg  <= px0_reg;
            py1_reg  <= py0_reg;
            pix1_reg <= pix0_reg;
            prx_reg  <= $signed(ang_q_reg[2*TRIG_W-1:TRIG_W]) * $signed({1'b0, rad_q_reg});
            pry_reg  <= $signed(ang_q_reg[TRIG_W-1:0]) * $signed({1'b0, rad_q_reg});
            wr2_reg  <= wr1_reg;
            px2_reg  <= px1_reg;
            py2_reg  <= py1_reg;
            pix2_reg <= pix1_reg;
            posx_reg <= posx_next;
            posy_reg <= posy_next;
            cmd_reg  <= cmd_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= acc && (img_ok || cmp_ok);
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end
endmodule
`default_nettype wire

### hdl/lpr_back.sv
// Back part: owns the source image memory, applies pixel writes, fetches four
// neighbours per compute command and blends them. Depends on lpr_pkg.
`default_nettype none
module lpr_back
    import lpr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               empty,
    output logic                    pop,
    input  cmd_t                    head,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output logic [PIX_W-1:0]        result_value,
    output logic [OIDX_W-1:0]       result_row,
    output logic [OIDX_W-1:0]       result_col
);
    localparam int AW = 2*SIDX_W;
    localparam int MW = PIX_W + FRAC_W;
    localparam int CW = MW + FRAC_W + 1;

    logic [PIX_W-1:0] img [SRC_SIDE*SRC_SIDE];

    logic en, done;
    logic cur_v_reg;
    cmd_t cur_reg;
    logic [1:0] ph_reg;
    logic [AW-1:0] addr;

    logic [PIX_W-1:0] rd_reg, p00_reg, p10_reg, p01_reg;
    logic rv_reg;
    logic [1:0] rph_reg;
    cmd_t rinfo_reg;

    logic av_reg, bv_reg, cv_reg, out_v_reg;
    logic [FRAC_W:0] wx0, wx1, wy0, wy1;
    logic [MW-1:0] m0_reg, m1_reg, m2_reg, m3_reg, top_reg, bot_reg;
    logic [FRAC_W-1:0] fya_reg, fyb_reg;
    logic [OIDX_W-1:0] rowa_reg, cola_reg, rowb_reg, colb_reg, rowc_reg, colc_reg;
    logic [CW-1:0] c0_reg, c1_reg, csum;
    logic [PIX_W-1:0] val_reg;
    logic [OIDX_W-1:0] row_reg, col_reg;

    assign en   = !(out_v_reg && res_stall);
    assign done = cur_reg.is_wr || (ph_reg == 2'd3);
    assign pop  = en && !empty && (!cur_v_reg || done);

    always_comb
    begin
        unique case (ph_reg)
            2'd0:    addr = {cur_reg.y0, cur_reg.x0};
            2'd1:    addr = {cur_reg.y0, cur_reg.x1};
            2'd2:    addr = {cur_reg.y1, cur_reg.x0};
            default: addr = {cur_reg.y1, cur_reg.x1};
        endcase
    end

    // Single port: a write command uses the cycle, otherwise one read.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (cur_v_reg && cur_reg.is_wr)
                img[addr] <= cur_reg.pix;
            else
                rd_reg <= img[addr];
        end
    end

    assign wx1 = {1'b0, rinfo_reg.fx};
    assign wx0 = (FRAC_W+1)'(1 << FRAC_W) - wx1;
    assign wy1 = {1'b0, fyb_reg};
    assign wy0 = (FRAC_W+1)'(1 << FRAC_W) - wy1;
    assign csum = c0_reg + c1_reg + CW'(1 << (2*FRAC_W-1));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rph_reg   <= ph_reg;
            rinfo_reg <= cur_reg;
            if (rv_reg && rph_reg == 2'd0)
                p00_reg <= rd_reg;
            if (rv_reg && rph_reg == 2'd1)
                p10_reg <= rd_reg;
            if (rv_reg && rph_reg == 2'd2)
                p01_reg <= rd_reg;
            m0_reg   <= MW'(p00_reg) * MW'(wx0);
            m1_reg   <= MW'(p10_reg) * MW'(wx1);
            m2_reg   <= MW'(p01_reg) * MW'(wx0);
            m3_reg   <= MW'(rd_reg) * MW'(wx1);
            fya_reg  <= rinfo_reg.fy;
            rowa_reg <= rinfo_reg.row;
            cola_reg <= rinfo_reg.col;
            top_reg  <= m0_reg + m1_reg;
            bot_reg  <= m2_reg + m3_reg;
            fyb_reg  <= fya_reg;
            rowb_reg <= rowa_reg;
            colb_reg <= cola_reg;
            c0_reg   <= CW'(top_reg) * CW'(wy0);
            c1_reg   <= CW'(bot_reg) * CW'(wy1);
            rowc_reg <= rowb_reg;
            colc_reg <= colb_reg;
            val_reg  <= csum[2*FRAC_W +: PIX_W];
            row_reg  <= rowc_reg;
            col_reg  <= colc_reg;
        end
        if (pop)
            cur_reg <= head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_v_reg <= 1'b0;
            ph_reg    <= 2'd0;
            rv_reg    <= 1'b0;
            av_reg    <= 1'b0;
            bv_reg    <= 1'b0;
            cv_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            rv_reg    <= cur_v_reg && !cur_reg.is_wr;
            av_reg    <= rv_reg && (rph_reg == 2'd3);
            bv_reg    <= av_reg;
            cv_reg    <= bv_reg;
            out_v_reg <= cv_reg;
            if (pop)
            begin
                cur_v_reg <= 1'b1;
                ph_reg    <= 2'd0;
            end
            else if (cur_v_reg && done)
            begin
                cur_v_reg <= 1'b0;
                ph_reg    <= 2'd0;
            end
            else if (cur_v_reg)
                ph_reg <= ph_reg + 2'd1;
        end
    end

    assign res_valid    = out_v_reg;
    assign result_value = val_reg;
    assign result_row   = row_reg;
    assign result_col   = col_reg;
endmodule
`default_nettype wire

### hdl/log_polar_remap_bilinear.sv
// Top level of the log-polar remap with bilinear sampling.
// Depends on lpr_pkg, lpr_front, lpr_fifo and lpr_back.
//
// The block maps output pixel (row, col) to the source position centre plus
// (cos[row], sin[row]) times radius[col], clamps it to the image and returns the
// bilinear blend of the four neighbours, rounded half up. Software fills the
// source image, the radius table and the angle table with request beats; a
// write beat gives no result. A compute beat outside the configured output
// size is dropped without a result. The front part takes one request beat per
// cycle unless stalled, updates the tables and works out the position in a
// four-stage pipeline, then hands commands through a four-entry queue to the
// back part. The back part owns one single-port image memory: a pixel write
// uses that port once and a compute command reads it once per neighbour; the
// next command leaves the queue only once the current one has done its last
// access, while earlier reads are still being blended. A stalled result beat
// freezes the whole back part, so the queue fills behind it and, once a command
// waits in the last front stage as well, the request channel stalls. The
// configuration registers are written through their own port, which is always
// ready; the user must write them only while the block is idle, which the
// block itself does not enforce.
`default_nettype none
module log_polar_remap_bilinear
    import lpr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [SIDE_W-1:0]  cfg_data,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire logic [1:0]         req_type,
    input  wire logic [SIDX_W-1:0]  pos_x,
    input  wire logic [SIDX_W-1:0]  pos_y,
    input  wire logic [PIX_W-1:0]   pixel_value,
    input  wire logic [OIDX_W-1:0]  table_index,
    input  wire logic [RAD_W-1:0]   radius_value,
    input  wire logic [TRIG_W-1:0]  cos_value,
    input  wire logic [TRIG_W-1:0]  sin_value,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output logic [PIX_W-1:0]        result_value,
    output logic [OIDX_W-1:0]       result_row,
    output logic [OIDX_W-1:0]       result_col
);
    logic [SIDE_W-1:0] src_w_reg, src_h_reg, out_w_reg, out_h_reg;
    sides_t sides;
    logic   push, full, pop, empty;
    cmd_t   push_cmd, head_cmd;

    assign cfg_ready = 1'b1;

    // Raw register values are kept; out-of-range sides are saturated here.
    assign sides.src_w = sat_side(src_w_reg, SIDE_W'(SRC_SIDE));
    assign sides.src_h = sat_side(src_h_reg, SIDE_W'(SRC_SIDE));
    assign sides.out_w = sat_side(out_w_reg, SIDE_W'(OUT_SIDE));
    assign sides.out_h = sat_side(out_h_reg, SIDE_W'(OUT_SIDE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= SIDE_W'(512);
            src_h_reg <= SIDE_W'(512);
            out_w_reg <= SIDE_W'(512);
            out_h_reg <= SIDE_W'(512);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SRC_W: src_w_reg <= cfg_data;
                CFG_SRC_H: src_h_reg <= cfg_data;
                CFG_OUT_W: out_w_reg <= cfg_data;
                CFG_OUT_H: out_h_reg <= cfg_data;
                default:   src_w_reg <= src_w_reg;
            endcase
        end
    end

    lpr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sides        (sides),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req_type     (req_type),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pixel_value  (pixel_value),
        .table_index  (table_index),
        .radius_value (radius_value),
        .cos_value    (cos_value),
        .sin_value    (sin_value),
        .push         (push),
        .cmd          (push_cmd),
        .full         (full)
    );

    lpr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .full      (full),
        .pop       (pop),
        .pop_data  (head_cmd),
        .empty     (empty)
    );

    lpr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .pop          (pop),
        .head         (head_cmd),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .result_value (result_value),
        .result_row   (result_row),
        .result_col   (result_col)
    );
endmodule
`default_nettype wire
